// ----- src/cpc_pkg.sv -----
// Package for the convex polygon plane clip unit: payload structs, sizes, register codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpc_pkg;
	localparam int MaxCorners = 16;
	localparam int BufCap = MaxCorners + 1;
	localparam int BufAw = $clog2(BufCap);
	localparam int CntW = $clog2(MaxCorners + 1);
	localparam int ResW = $clog2(BufCap + 1);
	localparam int MinCorners = 3;
	localparam int FracBits = 30;

	typedef enum logic [2:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_OFFSET = 3'd3,
		REG_TOL = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic final_vertex;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic run_end;
		logic clipped_away;
		logic vertex_overflow;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} corner_t;

	typedef struct packed {
		logic start;
		logic [31:0] num;
		logic [32:0] den;
	} div_req_t;
endpackage
`default_nettype wire

// ----- src/cpc_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cpc_ram #(
	parameter int Width = 96,
	parameter int Depth = 17
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- src/cpc_div.sv -----
// Restoring divider: frac = (num << 30) / den, one quotient bit per cycle.
// Depends on cpc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpc_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire cpc_pkg::div_req_t req,
	output logic busy,
	output logic [cpc_pkg::FracBits-1:0] frac
);
	import cpc_pkg::*;
	localparam int StepW = $clog2(FracBits + 1);
	logic [StepW-1:0] step_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [FracBits-1:0] quo_q;
	logic [33:0] trial;
	assign trial = {rem_q[32:0], 1'b0} - {1'b0, den_q};
	assign busy = step_q != '0;
	assign frac = quo_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (req.start) begin
			step_q <= StepW'(FracBits);
		end else if (busy) begin
			step_q <= step_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {2'b0, req.num};
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy) begin
			if (!trial[33]) begin
				rem_q <= trial;
				quo_q <= {quo_q[FracBits-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], 1'b0};
				quo_q <= {quo_q[FracBits-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/convex_polygon_plane_clip_unit.sv -----
// Top level of the convex polygon plane clip unit: sequencer, distance and lerp datapath.
// Depends on cpc_pkg, cpc_ram, cpc_div.
//
// Usage: corners of one polygon enter on in_valid/in_stall/in_data, one
// transaction each, Q16.16. Mark the last with final_vertex. A corner's plane
// distance is worked out in S_MUL (registered products), S_SUM (sum) and S_DIST
// (saturate), then its edge and bookkeeping in S_EDGE and S_NEXT. The first
// corner and corners beyond capacity skip S_EDGE. An edge that crosses the plane
// adds a wait in the iterative divider (30 quotient bits, one per cycle) and the
// states S_LERP1, S_LERP2 and S_PUSHC to interpolate and store the crossing point.
// Kept corners are written to a 17-entry result RAM. On the final corner the
// closing edge is walked through S_EDGE and S_NEXT, with the divider and
// interpolation steps if it crosses, then the RAM is read out as one run on
// out_valid/out_stall/out_data, each result by a RAM read and then an output load.
// A run with fewer than three corners is one result with clipped_away set.
// in_stall is high while a corner is in work or a run drains.
// The output register holds its value while out_stall is high, and the run
// waits for it. Reset clears the control state and restores the register defaults.
// Configuration is written on cfg_we/cfg_index/cfg_data; the user must do so only
// while idle, since the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module convex_polygon_plane_clip_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire cpc_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output cpc_pkg::out_item_t out_data
);
	import cpc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_SUM, S_DIST, S_EDGE, S_DIVW, S_LERP1, S_LERP2,
		S_PUSHC, S_NEXT, S_RD, S_EMIT, S_ONE
	} state_t;

	state_t state_q;
	logic signed [31:0] nx_q, ny_q, nz_q, off_q;
	logic [30:0] tol_q;
	corner_t cur_q, first_q, prev_q, a_q, b_q;
	logic signed [31:0] dfirst_q, dprev_q, da_q, db_q;
	logic [CntW-1:0] cnt_q;
	logic [ResW-1:0] res_q, rd_q;
	logic ovf_q, fin_q, closing_q;
	logic signed [63:0] px_s1, py_s1, pz_s1;
	logic signed [65:0] sum_s2;
	logic signed [66:0] dfull;
	logic signed [31:0] dsat;
	logic signed [63:0] lx_q, ly_q, lz_q;
	corner_t push_q;
	logic we;
	corner_t wdata, rdata;
	logic [BufAw-1:0] raddr;
	div_req_t dreq;
	logic dbusy;
	logic [FracBits-1:0] frac;
	logic [31:0] abs_db;
	logic sa_f, sa_b, sb_f, sb_b;
	logic out_load;

	function automatic logic signed [63:0] lerp_mul(logic signed [31:0] a,
			logic signed [31:0] b, logic [FracBits-1:0] f);
		logic signed [33:0] diff;
		diff = 34'(b) - 34'(a);
		return 64'(diff * $signed({1'b0, f}));
	endfunction

	function automatic logic signed [31:0] lerp_fin(logic signed [31:0] a,
			logic signed [63:0] m);
		logic signed [63:0] t;
		t = m + (64'sd1 <<< (FracBits - 1));
		return 32'(64'(a) + (t >>> FracBits));
	endfunction

	assign sa_f = 33'(da_q) > $signed({2'b0, tol_q});
	assign sa_b = 33'(da_q) < -$signed({2'b0, tol_q});
	assign sb_f = 33'(db_q) > $signed({2'b0, tol_q});
	assign sb_b = 33'(db_q) < -$signed({2'b0, tol_q});

	assign dfull = 67'(sum_s2 >>> 16) - 67'(off_q);
	assign dsat = (dfull > 67'sd2147483647) ? 32'sh7fffffff :
		(dfull < -67'sd2147483648) ? 32'sh80000000 : 32'(dfull);

	cpc_ram #(.Width(96), .Depth(BufCap)) u_buf (
		.clk(clk), .we(we), .waddr(res_q[BufAw-1:0]), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);
	assign raddr = rd_q[BufAw-1:0];

	cpc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .frac(frac));

	assign abs_db = db_q[31] ? 32'(-33'(db_q)) : 32'(db_q);

	always_comb begin
		we = 1'b0;
		wdata = a_q;
		dreq = '0;
		dreq.num = da_q[31] ? 32'(-33'(da_q)) : 32'(da_q);
		dreq.den = 33'(dreq.num) + 33'(abs_db);
		if (state_q == S_EDGE) begin
			we = !sa_f && res_q < ResW'(BufCap);
			dreq.start = (sa_f && sb_b) || (sa_b && sb_f);
		end else if (state_q == S_PUSHC) begin
			we = res_q < ResW'(BufCap);
			wdata = push_q;
		end
	end

	assign in_stall = state_q != S_IDLE;
	assign out_load = (state_q == S_EMIT || state_q == S_ONE) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nx_q <= '0; ny_q <= '0; nz_q <= 32'sd65536; off_q <= '0; tol_q <= 31'd66;
			cnt_q <= '0; res_q <= '0; rd_q <= '0; ovf_q <= 1'b0; fin_q <= 1'b0;
			closing_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_NORMAL_X: nx_q <= cfg_data;
					REG_NORMAL_Y: ny_q <= cfg_data;
					REG_NORMAL_Z: nz_q <= cfg_data;
					REG_OFFSET: off_q <= cfg_data;
					REG_TOL: tol_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_MUL;
					fin_q <= in_data.final_vertex;
				end
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_DIST;
				S_DIST: begin
					closing_q <= 1'b0;
					if (cnt_q < CntW'(MaxCorners)) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == '0) begin
							state_q <= S_NEXT;
						end else begin
							state_q <= S_EDGE;
						end
					end else begin
						ovf_q <= 1'b1;
						state_q <= S_NEXT;
					end
				end
				S_EDGE: begin
					if (we) res_q <= res_q + 1'b1;
					state_q <= dreq.start ? S_DIVW : S_NEXT;
				end
				S_DIVW: if (!dbusy) state_q <= S_LERP1;
				S_LERP1: state_q <= S_LERP2;
				S_LERP2: state_q <= S_PUSHC;
				S_PUSHC: begin
					if (we) res_q <= res_q + 1'b1;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (closing_q) begin
						rd_q <= '0;
						state_q <= (res_q < ResW'(MinCorners)) ? S_ONE : S_RD;
					end else if (cnt_q != '0) begin
						closing_q <= 1'b1;
						state_q <= S_EDGE;
					end else begin
						state_q <= S_ONE;
					end
				end
				S_RD: state_q <= S_EMIT;
				S_EMIT: if (out_load) begin
					out_data.out_x <= rdata.x;
					out_data.out_y <= rdata.y;
					out_data.out_z <= rdata.z;
					out_data.clipped_away <= 1'b0;
					out_data.vertex_overflow <= ovf_q;
					out_data.run_end <= rd_q + 1'b1 == res_q;
					if (rd_q + 1'b1 == res_q) begin
						state_q <= S_IDLE;
						cnt_q <= '0; res_q <= '0; ovf_q <= 1'b0; fin_q <= 1'b0;
					end else begin
						rd_q <= rd_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_ONE: if (out_load) begin
					out_data <= {96'b0, 1'b1, 1'b1, ovf_q};
					state_q <= S_IDLE;
					cnt_q <= '0; res_q <= '0; ovf_q <= 1'b0; fin_q <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid) begin
				cur_q <= {in_data.vertex_x, in_data.vertex_y, in_data.vertex_z};
			end
			S_MUL: begin
				px_s1 <= 64'(nx_q) * 64'(cur_q.x);
				py_s1 <= 64'(ny_q) * 64'(cur_q.y);
				pz_s1 <= 64'(nz_q) * 64'(cur_q.z);
			end
			S_SUM: sum_s2 <= 66'(px_s1) + 66'(py_s1) + 66'(pz_s1);
			S_DIST: begin
				a_q <= prev_q; da_q <= dprev_q;
				b_q <= cur_q; db_q <= dsat;
				if (cnt_q < CntW'(MaxCorners)) begin
					prev_q <= cur_q;
					dprev_q <= dsat;
					if (cnt_q == '0) begin
						first_q <= cur_q;
						dfirst_q <= dsat;
					end
				end
			end
			S_LERP1: begin
				lx_q <= lerp_mul(a_q.x, b_q.x, frac);
				ly_q <= lerp_mul(a_q.y, b_q.y, frac);
				lz_q <= lerp_mul(a_q.z, b_q.z, frac);
			end
			S_LERP2: push_q <= {lerp_fin(a_q.x, lx_q), lerp_fin(a_q.y, ly_q),
				lerp_fin(a_q.z, lz_q)};
			S_NEXT: begin
				if (fin_q && !closing_q && cnt_q != '0) begin
					a_q <= prev_q; da_q <= dprev_q;
					b_q <= first_q; db_q <= dfirst_q;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/cpc_checker.sv -----
// Port-level assertions for the convex polygon plane clip unit, bound to the top level.
// Depends on cpc_pkg and convex_polygon_plane_clip_unit.
`timescale 1ns / 1ps
`default_nettype none
module cpc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire cpc_pkg::out_item_t out_data
);
	import cpc_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clipped_away |-> out_data.run_end) else $error("empty end");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.clipped_away |-> out_data.out_x == 0 && out_data.out_z == 0)
		else $error("empty coords");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("busy");
endmodule
bind convex_polygon_plane_clip_unit cpc_checker u_chk (.*);
`default_nettype wire

// ----- test/convex_polygon_plane_clip_unit_tb.sv -----
// Testbench for convex_polygon_plane_clip_unit: drives polygons, predicts the clipped runs
// with a behavioral plane clipper, and checks every output transaction. Depends on cpc_pkg and the DUT.
`timescale 1ns / 1ps
module convex_polygon_plane_clip_unit_tb;
	import cpc_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;

	convex_polygon_plane_clip_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// plane registers
	longint nrm_x, nrm_y, nrm_z, pl_off, tol;
	// polygon state
	longint first_c[3], prev_c[3], first_d, prev_d;
	int corner_cnt;
	longint kept[$][3];
	bit ovf_seen;

	out_item_t expected_q[$];
	int err_cnt;
	int send_gap_pct, stall_pct;
	int quiet_cycles;
	localparam int QuietLimit = 20000;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic longint plane_distance(longint x, longint y, longint z);
		longint p[3], hi, lo, h, d;
		p[0] = nrm_x * x;
		p[1] = nrm_y * y;
		p[2] = nrm_z * z;
		hi = 0;
		lo = 0;
		for (int i = 0; i < 3; i++) begin
			h = p[i] >>> 16;
			hi += h;
			lo += p[i] - h * 65536;
		end
		d = hi + (lo >>> 16) - pl_off;
		if (d > 64'sd2147483647) d = 64'sd2147483647;
		if (d < -64'sd2147483648) d = -64'sd2147483648;
		return d;
	endfunction

	function automatic int side(longint d);
		if (d > tol) return 1;
		if (d < -tol) return -1;
		return 0;
	endfunction

	function automatic void keep_corner(longint x, longint y, longint z);
		longint c[3];
		c[0] = x; c[1] = y; c[2] = z;
		if (kept.size() < BufCap) kept.insert(kept.size(), c);
	endfunction

	function automatic void clip_edge(longint a[3], longint da, longint b[3], longint db);
		int sa, sb;
		longint num, den, frac, t[3];
		sa = side(da);
		sb = side(db);
		if (sa != 1) keep_corner(a[0], a[1], a[2]);
		if ((sa == 1 && sb == -1) || (sa == -1 && sb == 1)) begin
			num = da < 0 ? -da : da;
			den = num + (db < 0 ? -db : db);
			frac = den != 0 ? (num << FracBits) / den : 0;
			for (int i = 0; i < 3; i++)
				t[i] = a[i] + (((b[i] - a[i]) * frac + (longint'(1) << (FracBits - 1)))
					>>> FracBits);
			keep_corner(t[0], t[1], t[2]);
		end
	endfunction

	function automatic void predict_corner(in_item_t v);
		longint c[3], d;
		out_item_t r;
		c[0] = v.vertex_x; c[1] = v.vertex_y; c[2] = v.vertex_z;
		d = plane_distance(c[0], c[1], c[2]);
		if (corner_cnt < MaxCorners) begin
			if (corner_cnt == 0) begin
				first_c = c;
				first_d = d;
			end else
				clip_edge(prev_c, prev_d, c, d);
			prev_c = c;
			prev_d = d;
			corner_cnt++;
		end else
			ovf_seen = 1;
		if (!v.final_vertex) return;
		if (corner_cnt > 0) clip_edge(prev_c, prev_d, first_c, first_d);
		if (kept.size() < MinCorners) begin
			r = '0;
			r.run_end = 1;
			r.clipped_away = 1;
			r.vertex_overflow = ovf_seen;
			expected_q.insert(expected_q.size(), r);
		end else
			for (int k = 0; k < kept.size(); k++) begin
				r.out_x = kept[k][0][31:0];
				r.out_y = kept[k][1][31:0];
				r.out_z = kept[k][2][31:0];
				r.run_end = (k == kept.size() - 1);
				r.clipped_away = 0;
				r.vertex_overflow = ovf_seen;
				expected_q.insert(expected_q.size(), r);
			end
		corner_cnt = 0;
		kept.delete();
		ovf_seen = 0;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
		err_cnt++;
	endtask

	// output checker and random stall
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0)
					report_mismatch("unexpected transaction", out_data.out_x, 0);
				else begin
					e = expected_q.pop_front();
					if (out_data.out_x !== e.out_x) report_mismatch("out_x", out_data.out_x, e.out_x);
					if (out_data.out_y !== e.out_y) report_mismatch("out_y", out_data.out_y, e.out_y);
					if (out_data.out_z !== e.out_z) report_mismatch("out_z", out_data.out_z, e.out_z);
					if (out_data.run_end !== e.run_end)
						report_mismatch("run_end", out_data.run_end, e.run_end);
					if (out_data.clipped_away !== e.clipped_away)
						report_mismatch("clipped_away", out_data.clipped_away, e.clipped_away);
					if (out_data.vertex_overflow !== e.vertex_overflow)
						report_mismatch("vertex_overflow", out_data.vertex_overflow,
							e.vertex_overflow);
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// in_valid stays high after an accept until the next item or a drain; the DUT
	// is busy then, so nothing is taken twice
	task automatic send_corner(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
		in_item_t v;
		v.vertex_x = x; v.vertex_y = y; v.vertex_z = z; v.final_vertex = last;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_corner(v);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_NORMAL_X: nrm_x = longint'(signed'(val));
			REG_NORMAL_Y: nrm_y = longint'(signed'(val));
			REG_NORMAL_Z: nrm_z = longint'(signed'(val));
			REG_OFFSET: pl_off = longint'(signed'(val));
			REG_TOL: tol = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
		logic [31:0] off, logic [31:0] t);
		drain();
		write_reg(REG_NORMAL_X, nx);
		write_reg(REG_NORMAL_Y, ny);
		write_reg(REG_NORMAL_Z, nz);
		write_reg(REG_OFFSET, off);
		write_reg(REG_TOL, t);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(40 << 16)) - (20 << 16);
		endcase
	endfunction

	task automatic send_polygon(int n);
		for (int i = 0; i < n; i++)
			send_corner(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
	endtask

	task automatic test_directed();
		// square crossing z = 0 at default plane
		send_corner(32'hfffe0000, 32'hfffe0000, 32'hffff0000, 0);
		send_corner(32'h00020000, 32'hfffe0000, 32'hffff0000, 0);
		send_corner(32'h00020000, 32'h00020000, 32'h00010000, 0);
		send_corner(32'hfffe0000, 32'h00020000, 32'h00010000, 1);
		// fully in front: clipped away
		send_corner(0, 0, 32'h00050000, 0);
		send_corner(32'h00010000, 0, 32'h00050000, 0);
		send_corner(0, 32'h00010000, 32'h00050000, 1);
		// lone final corner
		send_corner(32'h80000000, 32'h7fffffff, 32'h80000000, 1);
		// two corners in the tolerance band, one far in front
		send_corner(0, 0, 32'd40, 0);
		send_corner(32'h00010000, 0, 32'hffffffc0, 0);
		send_corner(0, 32'h00010000, 32'h7fffffff, 1);
		// extremes
		send_corner(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
		send_corner(32'h80000000, 32'h7fffffff, 32'h80000000, 0);
		send_corner(32'hffffffff, 32'h00000001, 32'h7fffffff, 1);
	endtask

	task automatic test_overflow();
		send_polygon(MaxCorners + 3);
		send_polygon(MaxCorners);
		send_polygon(MaxCorners + 1);
	endtask

	task automatic test_random(int items);
		int n, sent;
		sent = 0;
		while (sent < items) begin
			n = ($urandom_range(19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
			if ($urandom_range(9) < 7)
				for (int i = 0; i < n; i++)
					send_corner($signed($urandom_range(16 << 16)) - (8 << 16),
						$signed($urandom_range(16 << 16)) - (8 << 16),
						$signed($urandom_range(16 << 16)) - (8 << 16), i == n - 1);
			else
				send_polygon(n);
			sent += n;
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		err_cnt = 0;
		quiet_cycles = 0;
		nrm_x = 0; nrm_y = 0; nrm_z = 65536; pl_off = 0; tol = 66;
		corner_cnt = 0;
		ovf_seen = 0;
		send_gap_pct = 24;
		stall_pct = 67;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		test_overflow();
		test_random(110);
		set_plane(32'h00010000, 32'hffff0000, 32'h00008000, 32'h00020000, 0);
		send_gap_pct = 67;
		stall_pct = 24;
		test_random(100);
		set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		test_random(30);
		set_plane($urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(1 << 17));
		send_gap_pct = 0;
		stall_pct = 0;
		test_random(70);
		set_plane(0, 32'h00010000, 0, 32'hffff0000, 32'h00001000);
		test_random(70);
		drain();
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/cpc_pkg.sv
src/cpc_ram.sv
src/cpc_div.sv
src/convex_polygon_plane_clip_unit.sv
src/cpc_checker.sv
test/convex_polygon_plane_clip_unit_tb.sv
